>>> rtl/core/glg_pkg.sv
// Package for the generation lease gate: payload types, command and state codes.
`timescale 1ns / 1ps

package glg_pkg;

   localparam logic [1:0] CMD_BEGIN   = 2'd0;
   localparam logic [1:0] CMD_QUERY   = 2'd1;
   localparam logic [1:0] CMD_RENEW   = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   localparam logic [1:0] ST_ABSENT  = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_READY   = 2'd2;

   localparam logic [62:0] GEN_MAX             = {63{1'b1}};
   localparam logic [31:0] LEASE_LENGTH_RESET  = 32'd1000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] now;
      logic [63:0] token;
      logic        running;
      logic        unlocked;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [62:0] granted_generation;
      logic        lease_valid;
      logic        lease_ready;
   } rsp_type;

endpackage

>>> rtl/core/glg_engine.sv
// Lease state registers and the single-pass command evaluation.
`timescale 1ns / 1ps

module glg_engine
   import glg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  req_type     req,
   input  logic [31:0] lease_length,
   output rsp_type     rsp
);

   logic [63:0] observed_time_ff, observed_time_in;
   logic [62:0] generation_ff, generation_in;
   logic [1:0]  state_ff, state_in;
   logic [63:0] deadline_ff, deadline_in;

   logic [64:0] sum;
   logic        clk_ok, fits, expired, tok_match;
   logic [62:0] gen_next;

   assign sum       = {1'b0, req.now} + {33'd0, lease_length};
   assign fits      = ~sum[64];
   assign clk_ok    = req.now >= observed_time_ff;
   assign expired   = (state_ff != ST_ABSENT) && (req.now >= deadline_ff);
   assign tok_match = (req.token != 64'd0) && (req.token == {1'b0, generation_ff});
   assign gen_next  = generation_ff + 63'd1;

   always_comb begin
      observed_time_in = observed_time_ff;
      generation_in    = generation_ff;
      state_in         = state_ff;
      deadline_in      = deadline_ff;
      rsp.ok                 = 1'b0;
      rsp.granted_generation = '0;
      case (req.cmd)
         CMD_BEGIN: begin
            state_in    = ST_ABSENT;
            deadline_in = '0;
            if (clk_ok) begin
               observed_time_in = req.now;
               if ((generation_ff != GEN_MAX) && fits) begin
                  generation_in          = gen_next;
                  state_in               = ST_PENDING;
                  deadline_in            = sum[63:0];
                  rsp.granted_generation = gen_next;
                  rsp.ok                 = 1'b1;
               end
            end
         end
         CMD_QUERY: begin
            if (!clk_ok || expired) begin
               state_in    = ST_ABSENT;
               deadline_in = '0;
            end else begin
               rsp.ok = state_ff != ST_ABSENT;
            end
            if (clk_ok) begin
               observed_time_in = req.now;
            end
         end
         CMD_RENEW: begin
            if (!clk_ok) begin
               state_in    = ST_ABSENT;
               deadline_in = '0;
            end else begin
               observed_time_in = req.now;
               if (tok_match && (state_ff != ST_ABSENT)) begin
                  // expiry, sender status or overflow all revoke
                  if (expired || !req.running || !req.unlocked || !fits) begin
                     state_in    = ST_ABSENT;
                     deadline_in = '0;
                  end else begin
                     state_in    = ST_READY;
                     deadline_in = sum[63:0];
                     rsp.ok      = 1'b1;
                  end
               end
            end
         end
         CMD_RELEASE: begin
            if (tok_match) begin
               state_in    = ST_ABSENT;
               deadline_in = '0;
               rsp.ok      = 1'b1;
            end
         end
         default: begin
            rsp.ok = 1'b0;
         end
      endcase
      rsp.lease_valid = state_in != ST_ABSENT;
      rsp.lease_ready = state_in == ST_READY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         observed_time_ff <= '0;
         generation_ff    <= '0;
         state_ff         <= ST_ABSENT;
         deadline_ff      <= '0;
      end else if (fire) begin
         observed_time_ff <= observed_time_in;
         generation_ff    <= generation_in;
         state_ff         <= state_in;
         deadline_ff      <= deadline_in;
      end
   end

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      fire |=> observed_time_ff >= $past(observed_time_ff))
      else $error("observed time went backward");

   a_gen_step: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.ok && (req.cmd == CMD_BEGIN)) |=>
         generation_ff == $past(generation_ff) + 63'd1)
      else $error("generation did not advance on granted begin");

   a_absent_no_deadline: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ABSENT) |-> (deadline_ff == 64'd0))
      else $error("absent lease holds a deadline");

endmodule

>>> rtl/core/generation_lease_gate_unit.sv
// Top level of the generation lease gate: request stage, result register, lease length.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_valid / req_ready  | req_data  (req_type)
//  rsp_    | out       | rsp_valid / rsp_ready  | rsp_data  (rsp_type)
//  csr_    | in        | csr_write              | csr_wdata (lease length)
//
// One request per cycle while the result is not stalled; the request is registered on
// acceptance, then the engine's compare/add pass is written into the result register,
// which offers it.
// A stalled result holds the engine; a request already registered waits behind it.
// Synchronous reset clears the lease state and sets lease length to 1000 ms.
`timescale 1ns / 1ps

module generation_lease_gate_unit
   import glg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [31:0] csr_wdata
);

   logic        s1_valid_ff;
   req_type     s1_req_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [31:0] lease_length_ff;
   logic        fire;
   rsp_type     eng_rsp;

   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   glg_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .req          (s1_req_ff),
      .lease_length (lease_length_ff),
      .rsp          (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         lease_length_ff <= LEASE_LENGTH_RESET;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            lease_length_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= eng_rsp;
      end
   end

   a_ready_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.lease_valid || !rsp_ff.lease_ready))
      else $error("lease ready without lease valid");

   a_grant_means_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.granted_generation != 63'd0)) |-> rsp_ff.ok)
      else $error("generation granted on a failed request");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request refused with an empty stage");

endmodule
